FILE: rtl/pidd_pkg.sv
// Shared types and constants for the three-wheel incremental PID drive.
// Used by pidd_lane, pidd_merge and three_wheel_incremental_pid_drive_unit.
`timescale 1ns / 1ps
`default_nettype none

package pidd_pkg;

  localparam int FIELD_WHEELS = 3;

  localparam int CNT_W  = 16;  // encoder count, target
  localparam int GAIN_W = 16;  // unsigned Q4.F gain
  localparam int CMP_W  = 15;  // PWM compare value
  localparam int LIM_W  = 16;  // signed low limit
  localparam int CFG_W  = 16;  // widest register
  localparam int IDX_W  = 3;

  localparam int ERR_W  = CNT_W + 1;       // e = target - count
  localparam int DP_W   = ERR_W + 1;       // e - e1
  localparam int DD_W   = ERR_W + 2;       // e - 2*e1 + e2
  localparam int PROD_W = GAIN_W + DD_W + 1;
  localparam int INC_W  = PROD_W + 2;
  localparam int ACC_W  = 40;
  localparam int SUM_W  = INC_W + 3;       // acc + inc, never wraps
  localparam int DRV_W  = CNT_W + 1;       // integer drive after truncation

  localparam logic [CMP_W-1:0] CMP_MAX = {CMP_W{1'b1}};

  localparam logic [GAIN_W-1:0]        KP_RESET  = 16'd2048;
  localparam logic [GAIN_W-1:0]        KI_RESET  = 16'd410;
  localparam logic [GAIN_W-1:0]        KD_RESET  = 16'd0;
  localparam logic [CMP_W-1:0]         LIM_HI_RESET = 15'd1000;
  localparam logic signed [LIM_W-1:0]  LIM_LO_RESET = -16'sd1000;

  typedef enum logic [IDX_W-1:0] {
    REG_KP        = 3'd0,
    REG_KI        = 3'd1,
    REG_KD        = 3'd2,
    REG_TGT_FRONT = 3'd3,
    REG_TGT_RIGHT = 3'd4,
    REG_TGT_LEFT  = 3'd5,
    REG_LIM_HIGH  = 3'd6,
    REG_LIM_LOW   = 3'd7
  } pidd_reg_t;

  typedef struct packed {
    logic signed [CNT_W-1:0] count_front;
    logic signed [CNT_W-1:0] count_right;
    logic signed [CNT_W-1:0] count_left;
  } pidd_in_t;

  typedef struct packed {
    logic [CMP_W-1:0] front_forward_compare;
    logic [CMP_W-1:0] front_reverse_compare;
    logic [CMP_W-1:0] right_forward_compare;
    logic [CMP_W-1:0] right_reverse_compare;
    logic [CMP_W-1:0] left_forward_compare;
    logic [CMP_W-1:0] left_reverse_compare;
  } pidd_out_t;

  typedef struct packed {
    logic [GAIN_W-1:0]       kp;
    logic [GAIN_W-1:0]       ki;
    logic [GAIN_W-1:0]       kd;
    logic [CMP_W-1:0]        lim_hi;
    logic signed [LIM_W-1:0] lim_lo;
  } pidd_cfg_t;

  // stage load strobes, one per lane pipeline stage
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } pidd_adv_t;

endpackage

`default_nettype wire

FILE: rtl/pidd_lane.sv
// One wheel's PID datapath: error history, gain products, accumulator update.
// Depends on pidd_pkg; stage strobes come from the top level.
`timescale 1ns / 1ps
`default_nettype none

module pidd_lane #(
  parameter int FRAC = 12
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pidd_pkg::pidd_adv_t                 adv,
  input  pidd_pkg::pidd_cfg_t                 cfg,
  input  logic signed [pidd_pkg::CNT_W-1:0]   target,
  input  logic signed [pidd_pkg::CNT_W-1:0]   count,
  output logic signed [pidd_pkg::ACC_W-1:0]   acc
);

  localparam int ERR_W  = pidd_pkg::ERR_W;
  localparam int DP_W   = pidd_pkg::DP_W;
  localparam int DD_W   = pidd_pkg::DD_W;
  localparam int PROD_W = pidd_pkg::PROD_W;
  localparam int INC_W  = pidd_pkg::INC_W;
  localparam int SUM_W  = pidd_pkg::SUM_W;
  localparam int ACC_W  = pidd_pkg::ACC_W;

  logic signed [ERR_W-1:0]  last_err, prev_err;
  logic signed [ERR_W-1:0]  err;
  logic signed [DP_W-1:0]   dp;
  logic signed [DD_W-1:0]   dd;

  logic signed [ERR_W-1:0]  s1_e;
  logic signed [DP_W-1:0]   s1_dp;
  logic signed [DD_W-1:0]   s1_dd;
  logic signed [PROD_W-1:0] s2_p, s2_i, s2_d;
  logic signed [INC_W-1:0]  s3_inc;

  logic signed [SUM_W-1:0]  sum, hi, lo, acc_next;

  // stage 1: error and its differences
  assign err = ERR_W'(target) - ERR_W'(count);
  assign dp  = DP_W'(err) - DP_W'(last_err);
  assign dd  = DD_W'(err) - (DD_W'(last_err) <<< 1) + DD_W'(prev_err);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_err <= '0;
      prev_err <= '0;
    end else if (adv.s1) begin
      prev_err <= last_err;
      last_err <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      s1_e  <= err;
      s1_dp <= dp;
      s1_dd <= dd;
    end
  end

  // stage 2: three gain products side by side
  always_ff @(posedge clk) begin
    if (adv.s2) begin
      s2_p <= PROD_W'($signed({1'b0, cfg.kp})) * PROD_W'(s1_dp);
      s2_i <= PROD_W'($signed({1'b0, cfg.ki})) * PROD_W'(s1_e);
      s2_d <= PROD_W'($signed({1'b0, cfg.kd})) * PROD_W'(s1_dd);
    end
  end

  // stage 3: increment
  always_ff @(posedge clk) begin
    if (adv.s3) begin
      s3_inc <= INC_W'(s2_p) + INC_W'(s2_i) + INC_W'(s2_d);
    end
  end

  // stage 4: accumulate and clamp, high limit checked first
  assign sum = SUM_W'(acc) + SUM_W'(s3_inc);
  assign hi  = SUM_W'($signed({1'b0, cfg.lim_hi})) <<< FRAC;
  assign lo  = SUM_W'(cfg.lim_lo) <<< FRAC;

  always_comb begin
    if (sum > hi) begin
      acc_next = hi;
    end else if (sum < lo) begin
      acc_next = lo;
    end else begin
      acc_next = sum;
    end
  end

  // the accumulator doubles as the stage 4 payload
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (adv.s4) begin
      acc <= ACC_W'(acc_next);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/pidd_merge.sv
// Output stage: turns each lane's accumulator into an H-bridge compare pair
// and holds the result beat. Depends on pidd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pidd_merge #(
  parameter int FRAC = 12
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic                               take,
  input  pidd_pkg::pidd_cfg_t                cfg,
  input  logic signed [pidd_pkg::ACC_W-1:0]  acc [pidd_pkg::FIELD_WHEELS],
  output logic                               valid,
  output pidd_pkg::pidd_out_t                data
);

  localparam int WHEELS = pidd_pkg::FIELD_WHEELS;
  localparam int ACC_W  = pidd_pkg::ACC_W;
  localparam int DRV_W  = pidd_pkg::DRV_W;
  localparam int CMP_W  = pidd_pkg::CMP_W;

  logic signed [DRV_W-1:0] hi, lo;
  logic signed [DRV_W-1:0] whole [WHEELS];
  logic signed [DRV_W-1:0] drv   [WHEELS];
  logic signed [DRV_W-1:0] mag   [WHEELS];
  logic [CMP_W-1:0]        fwd   [WHEELS];
  logic [CMP_W-1:0]        rev   [WHEELS];

  assign hi = $signed({2'b00, cfg.lim_hi});
  assign lo = DRV_W'(cfg.lim_lo);

  always_comb begin
    for (int w = 0; w < WHEELS; w++) begin
      // truncate toward zero: floor, plus one for negative with a fraction
      whole[w] = DRV_W'(acc[w] >>> FRAC)
               + DRV_W'(acc[w][ACC_W-1] && (acc[w][FRAC-1:0] != '0));
      if (whole[w] > hi) begin
        drv[w] = hi;
      end else if (whole[w] < lo) begin
        drv[w] = lo;
      end else begin
        drv[w] = whole[w];
      end
      mag[w] = -drv[w];
      fwd[w] = '0;
      rev[w] = '0;
      if (drv[w] > 0) begin
        fwd[w] = drv[w][CMP_W-1:0];
      end else if (drv[w] < 0) begin
        rev[w] = (mag[w] > $signed({2'b00, pidd_pkg::CMP_MAX})) ?
                 pidd_pkg::CMP_MAX : mag[w][CMP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data.front_forward_compare <= fwd[0];
      data.front_reverse_compare <= rev[0];
      data.right_forward_compare <= fwd[1];
      data.right_reverse_compare <= rev[1];
      data.left_forward_compare  <= fwd[2];
      data.left_reverse_compare  <= rev[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/three_wheel_incremental_pid_drive_unit.sv
// Top level of the three-wheel incremental PID drive: config registers,
// pipeline flow control, wheel lanes and output stage. Uses pidd_pkg,
// pidd_lane and pidd_merge.
//
//   channel   dir  handshake              payload
//   count     in   count_valid/stall      pidd_in_t  (three encoder counts)
//   compare   out  compare_valid/stall    pidd_out_t (six PWM compares)
//   cfg       in   cfg_wr_en              cfg_index, cfg_data (16 bits)
//
// An accepted count beat passes five registered stages to its compare
// beat: error, products, increment, accumulate, output register. One beat
// per cycle sustained while compare_stall is low; the accumulator loop
// closes within the accumulate stage. Each stage holds its beat while the
// next is full, so bubbles collapse and a count beat is taken while a
// compare beat waits on stall as long as some stage is empty; with all
// five full, count_stall follows compare_stall.
// Synchronous reset clears accumulators, error history, valids and loads
// the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module three_wheel_incremental_pid_drive_unit #(
  parameter int WHEEL_COUNT        = 3,
  parameter int GAIN_FRACTION_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              count_valid,
  output logic                              count_stall,
  input  pidd_pkg::pidd_in_t                count,
  output logic                              compare_valid,
  input  logic                              compare_stall,
  output pidd_pkg::pidd_out_t               compare,
  input  logic                              cfg_wr_en,
  input  logic [pidd_pkg::IDX_W-1:0]        cfg_index,
  input  logic [pidd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int WHEELS = pidd_pkg::FIELD_WHEELS;
  localparam int CNT_W  = pidd_pkg::CNT_W;

  // ---------------------------------------------------------------- config
  pidd_pkg::pidd_cfg_t     cfg;
  logic signed [CNT_W-1:0] tgt [WHEELS];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kp     <= pidd_pkg::KP_RESET;
      cfg.ki     <= pidd_pkg::KI_RESET;
      cfg.kd     <= pidd_pkg::KD_RESET;
      cfg.lim_hi <= pidd_pkg::LIM_HI_RESET;
      cfg.lim_lo <= pidd_pkg::LIM_LO_RESET;
      tgt[0]     <= '0;
      tgt[1]     <= '0;
      tgt[2]     <= '0;
    end else if (cfg_wr_en) begin
      case (pidd_pkg::pidd_reg_t'(cfg_index))
        pidd_pkg::REG_KP:        cfg.kp     <= cfg_data;
        pidd_pkg::REG_KI:        cfg.ki     <= cfg_data;
        pidd_pkg::REG_KD:        cfg.kd     <= cfg_data;
        pidd_pkg::REG_TGT_FRONT: tgt[0]     <= $signed(cfg_data);
        pidd_pkg::REG_TGT_RIGHT: tgt[1]     <= $signed(cfg_data);
        pidd_pkg::REG_TGT_LEFT:  tgt[2]     <= $signed(cfg_data);
        pidd_pkg::REG_LIM_HIGH:  cfg.lim_hi <= cfg_data[pidd_pkg::CMP_W-1:0];
        pidd_pkg::REG_LIM_LOW:   cfg.lim_lo <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // ----------------------------------------------------------- flow control
  // rdy_k: stage k can take a beat this cycle (empty, or emptying)
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, rdy_o;
  logic load_o, take_o;
  pidd_pkg::pidd_adv_t adv;

  assign take_o = compare_valid && !compare_stall;
  assign rdy_o  = !compare_valid || !compare_stall;
  assign rdy4   = !v4 || rdy_o;
  assign rdy3   = !v3 || rdy4;
  assign rdy2   = !v2 || rdy3;
  assign rdy1   = !v1 || rdy2;

  assign count_stall = !rdy1;

  assign adv.s1 = count_valid && rdy1;
  assign adv.s2 = v1 && rdy2;
  assign adv.s3 = v2 && rdy3;
  assign adv.s4 = v3 && rdy4;
  assign load_o = v4 && rdy_o;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= adv.s1 || (v1 && !adv.s2);
      v2 <= adv.s2 || (v2 && !adv.s3);
      v3 <= adv.s3 || (v3 && !adv.s4);
      v4 <= adv.s4 || (v4 && !load_o);
    end
  end

  // ------------------------------------------------------------------ lanes
  logic signed [CNT_W-1:0]           cnt [WHEELS];
  logic signed [pidd_pkg::ACC_W-1:0] lane_acc [WHEELS];

  assign cnt[0] = count.count_front;
  assign cnt[1] = count.count_right;
  assign cnt[2] = count.count_left;

  for (genvar w = 0; w < WHEELS; w++) begin : g_lane
    if (w < WHEEL_COUNT) begin : g_on
      pidd_lane #(
        .FRAC (GAIN_FRACTION_BITS)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .adv    (adv),
        .cfg    (cfg),
        .target (tgt[w]),
        .count  (cnt[w]),
        .acc    (lane_acc[w])
      );
    end else begin : g_off
      // wheel not fitted: accumulator stays at zero
      assign lane_acc[w] = '0;
    end
  end

  // ----------------------------------------------------------- output stage
  pidd_merge #(
    .FRAC (GAIN_FRACTION_BITS)
  ) u_merge (
    .clk   (clk),
    .rst   (rst),
    .load  (load_o),
    .take  (take_o),
    .cfg   (cfg),
    .acc   (lane_acc),
    .valid (compare_valid),
    .data  (compare)
  );

  // ------------------------------------------------------------- assertions
  // an empty output register means the whole pipe drains, so input is open
  a_open_when_empty: assert property (@(posedge clk) disable iff (rst)
    !compare_valid |-> !count_stall)
    else $error("count stalled with empty output register");

  // a result beat only appears after stage 4 held one
  a_rise_from_s4: assert property (@(posedge clk) disable iff (rst)
    $rose(compare_valid) |-> $past(v4))
    else $error("compare beat without a stage 4 beat");

  // a bridge never drives both sides at once
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    compare_valid |->
      !(compare.front_forward_compare != '0 && compare.front_reverse_compare != '0) &&
      !(compare.right_forward_compare != '0 && compare.right_reverse_compare != '0) &&
      !(compare.left_forward_compare  != '0 && compare.left_reverse_compare  != '0))
    else $error("forward and reverse compare both set");

endmodule

`default_nettype wire

FILE: sim/three_wheel_incremental_pid_drive_unit_test.sv
// Self-checking bench for the three-wheel incremental PID drive unit.
// Depends on pidd_pkg and three_wheel_incremental_pid_drive_unit from rtl/.
`timescale 1ns / 1ps

module three_wheel_incremental_pid_drive_unit_test;

  localparam int     FRAC = 12;
  localparam longint UNIT = 64'sd1 << FRAC;  // one drive step in accumulator units

  logic                        clk           = 1'b0;
  logic                        rst           = 1'b1;
  logic                        count_valid   = 1'b0;
  logic                        count_stall;
  pidd_pkg::pidd_in_t          count         = '0;
  logic                        compare_valid;
  logic                        compare_stall = 1'b0;
  pidd_pkg::pidd_out_t         compare;
  logic                        cfg_wr_en     = 1'b0;
  logic [pidd_pkg::IDX_W-1:0]  cfg_index     = '0;
  logic [pidd_pkg::CFG_W-1:0]  cfg_data      = '0;

  three_wheel_incremental_pid_drive_unit #(
    .WHEEL_COUNT       (pidd_pkg::FIELD_WHEELS),
    .GAIN_FRACTION_BITS(FRAC)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .count_valid  (count_valid),
    .count_stall  (count_stall),
    .count        (count),
    .compare_valid(compare_valid),
    .compare_stall(compare_stall),
    .compare      (compare),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Count beats waiting for the driver, and compare beats still owed by the unit.
  pidd_pkg::pidd_in_t  count_beats[$];
  pidd_pkg::pidd_out_t expected_compares[$];
  int        beats_sent  = 0;
  int        beats_taken = 0;
  int        mismatches  = 0;
  logic      count_taken = 1'b0;

  // Percent of cycles in which each side holds off.
  int send_idle = 6;
  int recv_idle = 74;

  // Register values of the current phase, as written.
  logic [pidd_pkg::CFG_W-1:0] reg_val [8];

  // Shadow of the unit's registers and per-wheel loop state.
  longint gain_p, gain_i, gain_d, hi_limit, lo_limit;
  longint target_of [pidd_pkg::FIELD_WHEELS];
  longint wheel_acc [pidd_pkg::FIELD_WHEELS];
  longint err_last  [pidd_pkg::FIELD_WHEELS];
  longint err_prev  [pidd_pkg::FIELD_WHEELS];

  string field_name [6] = '{"left_reverse", "left_forward", "right_reverse",
                            "right_forward", "front_reverse", "front_forward"};

  // High bound wins; the low bound is only looked at when the high one did not hit.
  function automatic longint clamp_high_first(longint x, longint hi, longint lo);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  // One control tick: velocity-form PID per wheel, then H-bridge split.
  function automatic pidd_pkg::pidd_out_t drive_step(pidd_pkg::pidd_in_t c);
    longint           cnt [pidd_pkg::FIELD_WHEELS];
    longint           err, incr, acc, drv;
    logic [5:0][14:0] f;
    int               w;
    cnt[0] = longint'($signed(c.count_front));
    cnt[1] = longint'($signed(c.count_right));
    cnt[2] = longint'($signed(c.count_left));
    f = '0;
    for (w = 0; w < pidd_pkg::FIELD_WHEELS; w++) begin
      err  = target_of[w] - cnt[w];
      incr = gain_p * (err - err_last[w]) + gain_i * err
           + gain_d * (err - 2 * err_last[w] + err_prev[w]);
      err_prev[w] = err_last[w];
      err_last[w] = err;
      acc = clamp_high_first(wheel_acc[w] + incr, hi_limit * UNIT, lo_limit * UNIT);
      wheel_acc[w] = acc;
      // integer part truncates toward zero, then the same ordered clamp
      drv = clamp_high_first(acc / UNIT, hi_limit, lo_limit);
      if (drv > 0)
        f[5 - 2 * w] = (drv > 32767) ? pidd_pkg::CMP_MAX : drv[14:0];
      else if (drv < 0)
        f[4 - 2 * w] = (-drv > 32767) ? pidd_pkg::CMP_MAX : 15'(-drv);
    end
    return pidd_pkg::pidd_out_t'(f);
  endfunction

  // Driver: count payload and compare stall change on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      count_valid   <= 1'b0;
      compare_stall <= 1'b0;
    end else begin
      compare_stall <= ($urandom_range(99) < recv_idle);
      if (!count_valid || count_taken) begin
        if (count_beats.size() != 0 && $urandom_range(99) >= send_idle) begin
          count       <= count_beats.pop_front();
          count_valid <= 1'b1;
        end else begin
          count_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks compare beats, predicts on count beats, shadows register writes.
  always @(posedge clk) begin : monitor
    pidd_pkg::pidd_out_t want;
    logic [5:0][14:0]    want_f, got_f;
    int                  w, k;
    if (rst) begin
      count_taken <= 1'b0;
      gain_p   = pidd_pkg::KP_RESET;
      gain_i   = pidd_pkg::KI_RESET;
      gain_d   = pidd_pkg::KD_RESET;
      hi_limit = pidd_pkg::LIM_HI_RESET;
      lo_limit = longint'(pidd_pkg::LIM_LO_RESET);
      for (w = 0; w < pidd_pkg::FIELD_WHEELS; w++) begin
        target_of[w] = 0;
        wheel_acc[w] = 0;
        err_last[w]  = 0;
        err_prev[w]  = 0;
      end
    end else begin
      if (compare_valid && !compare_stall) begin
        if (expected_compares.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: compare beat with nothing expected", $time);
          mismatches++;
        end else begin
          want   = expected_compares.pop_front();
          want_f = want;
          got_f  = compare;
          for (k = 0; k < 6; k++) begin
            if (got_f[k] !== want_f[k]) begin
              if (mismatches < 10)
                $display("%0t: %s expected %0d, got %0d", $time, field_name[k],
                         want_f[k], got_f[k]);
              mismatches++;
            end
          end
        end
      end
      count_taken <= count_valid && !count_stall;
      if (count_valid && !count_stall) begin
        expected_compares.push_back(drive_step(count));
        beats_taken++;
      end
      // writes only happen while idle, so they never race a prediction
      if (cfg_wr_en) begin
        case (pidd_pkg::pidd_reg_t'(cfg_index))
          pidd_pkg::REG_KP:        gain_p = cfg_data;
          pidd_pkg::REG_KI:        gain_i = cfg_data;
          pidd_pkg::REG_KD:        gain_d = cfg_data;
          pidd_pkg::REG_TGT_FRONT: target_of[0] = longint'($signed(cfg_data));
          pidd_pkg::REG_TGT_RIGHT: target_of[1] = longint'($signed(cfg_data));
          pidd_pkg::REG_TGT_LEFT:  target_of[2] = longint'($signed(cfg_data));
          pidd_pkg::REG_LIM_HIGH:  hi_limit = cfg_data[pidd_pkg::CMP_W-1:0];
          pidd_pkg::REG_LIM_LOW:   lo_limit = longint'($signed(cfg_data));
          default:                 ;
        endcase
      end
    end
  end

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'hffff;
      2, 3:    return 16'($urandom);
      default: return 16'($urandom_range(8192));
    endcase
  endfunction

  function automatic logic [15:0] pick_target();
    case ($urandom_range(7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(4000)) - 16'd2000;
    endcase
  endfunction

  // raw 16-bit value; bit 15 is dropped by the 15-bit register
  function automatic logic [15:0] pick_high();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'h7fff;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(5000, 1));
    endcase
  endfunction

  // mostly negative; zero, -32768 and positive values stress the ordered clamp
  function automatic logic [15:0] pick_low();
    case ($urandom_range(9))
      0:       return 16'd0;
      1:       return 16'h8001;
      2:       return 16'h8000;
      3:       return 16'($urandom_range(3000, 1));
      4:       return 16'($urandom);
      default: return 16'd0 - 16'($urandom_range(5000, 1));
    endcase
  endfunction

  // Closed-loop style counts: mostly near the target, some full-scale noise.
  function automatic logic [15:0] pick_count(logic [15:0] tgt);
    case ($urandom_range(19))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return 16'd0;
      3, 4, 5: return 16'($urandom);
      default: return tgt + 16'($urandom_range(64)) - 16'd32;
    endcase
  endfunction

  task automatic push_counts(input logic [15:0] f, r, l);
    pidd_pkg::pidd_in_t b;
    b.count_front = f;
    b.count_right = r;
    b.count_left  = l;
    count_beats.push_back(b);
    beats_sent++;
  endtask

  // Wait until every count beat is in and every compare beat is out, plus pipeline slack.
  task automatic settle();
    do @(negedge clk);
    while (beats_taken != beats_sent || expected_compares.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  // Writes all eight registers back to back; called only while idle.
  task automatic program_regs(input logic [15:0] kp, ki, kd, tf, tr, tl, hi, lo);
    pidd_pkg::pidd_reg_t r;
    reg_val[pidd_pkg::REG_KP]        = kp;
    reg_val[pidd_pkg::REG_KI]        = ki;
    reg_val[pidd_pkg::REG_KD]        = kd;
    reg_val[pidd_pkg::REG_TGT_FRONT] = tf;
    reg_val[pidd_pkg::REG_TGT_RIGHT] = tr;
    reg_val[pidd_pkg::REG_TGT_LEFT]  = tl;
    reg_val[pidd_pkg::REG_LIM_HIGH]  = hi;
    reg_val[pidd_pkg::REG_LIM_LOW]   = lo;
    r = r.first();
    repeat (8) begin
      @(negedge clk);
      cfg_wr_en <= 1'b1;
      cfg_index <= r;
      cfg_data  <= reg_val[r];
      r = r.next();
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int ph, n;
    reg_val[pidd_pkg::REG_KP]        = pidd_pkg::KP_RESET;
    reg_val[pidd_pkg::REG_KI]        = pidd_pkg::KI_RESET;
    reg_val[pidd_pkg::REG_KD]        = pidd_pkg::KD_RESET;
    reg_val[pidd_pkg::REG_TGT_FRONT] = '0;
    reg_val[pidd_pkg::REG_TGT_RIGHT] = '0;
    reg_val[pidd_pkg::REG_TGT_LEFT]  = '0;
    reg_val[pidd_pkg::REG_LIM_HIGH]  = 16'(pidd_pkg::LIM_HI_RESET);
    reg_val[pidd_pkg::REG_LIM_LOW]   = pidd_pkg::LIM_LO_RESET;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: full-scale counts drive both clamps, small ones stay linear.
    @(posedge clk);
    push_counts(16'd0, 16'd0, 16'd0);
    push_counts(16'd1, 16'hffff, 16'd0);
    push_counts(16'h7fff, 16'h8000, 16'd0);
    push_counts(16'h7fff, 16'h8000, 16'd0);
    push_counts(16'h8000, 16'h7fff, 16'h5555);
    push_counts(16'haaaa, 16'd0, 16'hffff);
    push_counts(16'd0, 16'd0, 16'd0);
    push_counts(16'hffff, 16'd1, 16'h7fff);
    settle();

    // Max gains, full-scale targets, low limit at -32768: reverse compare saturates.
    program_regs(16'hffff, 16'hffff, 16'hffff, 16'h7fff, 16'h8000, 16'hffff,
                 16'hffff, 16'h8000);
    @(posedge clk);
    push_counts(16'h8000, 16'h7fff, 16'd0);
    push_counts(16'h7fff, 16'h8000, 16'hffff);
    push_counts(16'h8000, 16'h7fff, 16'h7fff);
    push_counts(16'd0, 16'd0, 16'h8000);
    push_counts(16'h7fff, 16'h7fff, 16'h7fff);
    push_counts(16'h8000, 16'h8000, 16'h8000);
    settle();

    // Low limit above the high limit: ordered clamps pick the result.
    program_regs(16'd0, 16'h1000, 16'h0800, 16'd0, 16'd0, 16'd0, 16'd100, 16'd500);
    @(posedge clk);
    push_counts(16'hffce, 16'd50, 16'd0);
    push_counts(16'd200, 16'hff38, 16'd0);
    push_counts(16'd0, 16'd0, 16'd0);
    push_counts(16'hfc18, 16'd1000, 16'd5);
    settle();

    // Both limits at zero: every compare stays zero.
    program_regs(pidd_pkg::KP_RESET, pidd_pkg::KI_RESET, pidd_pkg::KD_RESET,
                 16'd3, 16'hfffd, 16'd100, 16'd0, 16'd0);
    @(posedge clk);
    push_counts(16'd0, 16'd0, 16'd0);
    push_counts(16'd100, 16'hff9c, 16'd7);
    push_counts(16'hfff9, 16'd7, 16'hfff9);
    settle();

    // Random phases: fresh register set each time, idling pattern in three stages.
    for (ph = 0; ph < 12; ph++) begin
      program_regs(pick_gain(), pick_gain(), pick_gain(),
                   pick_target(), pick_target(), pick_target(),
                   (ph == 1) ? 16'h7fff : pick_high(),
                   (ph == 1) ? 16'h8001 : pick_low());
      @(posedge clk);
      if (ph == 4) begin
        send_idle = 74;
        recv_idle = 6;
      end else if (ph == 8) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (n = 0; n < 125; n++)
        push_counts(pick_count(reg_val[pidd_pkg::REG_TGT_FRONT]),
                    pick_count(reg_val[pidd_pkg::REG_TGT_RIGHT]),
                    pick_count(reg_val[pidd_pkg::REG_TGT_LEFT]));
      settle();
    end

    if (mismatches == 0 && expected_compares.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

FILE: three_wheel_incremental_pid_drive_unit.f
rtl/pidd_pkg.sv
rtl/pidd_lane.sv
rtl/pidd_merge.sv
rtl/three_wheel_incremental_pid_drive_unit.sv
sim/three_wheel_incremental_pid_drive_unit_test.sv
